FILE: src/lfs_pkg.sv
package lfs_pkg;

    // Parser phases
    localparam logic [1:0] PH_ID      = 2'd0;
    localparam logic [1:0] PH_SIZE    = 2'd1;
    localparam logic [1:0] PH_CONTENT = 2'd2;

    // Field ids, first character in the highest byte
    localparam logic [23:0] ID_ETT = 24'h455454;
    localparam logic [23:0] ID_EAR = 24'h454152;
    localparam logic [23:0] ID_EAL = 24'h45414C;
    localparam logic [23:0] ID_LYR = 24'h4C5952;
    localparam logic [23:0] ID_IND = 24'h494E44;

    // Field kinds; bit 2 set means the field is not emitted
    localparam logic [2:0] KIND_TITLE  = 3'd0;
    localparam logic [2:0] KIND_ARTIST = 3'd1;
    localparam logic [2:0] KIND_ALBUM  = 3'd2;
    localparam logic [2:0] KIND_LYRICS = 3'd3;
    localparam logic [2:0] KIND_NONE   = 3'd4;

    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] STAMP_OPEN = 8'h5B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    localparam logic [2:0] STAMP_TAIL   = 3'd6;
    localparam logic [2:0] ID_LAST_CNT  = 3'd2;  // count before the third id byte
    localparam logic [2:0] HDR_LAST_CNT = 3'd7;  // count at the last size digit
    localparam logic [1:0] IND_FLAG_POS = 2'd1;
    localparam logic [1:0] INDEX_MAX    = 2'd3;

    localparam int SIZE_W = 17;

    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic [1:0] kind;
        logic       byte_valid;
        logic       field_end;
    } t_lfs_result;

    function automatic logic [2:0] kind_of_id(input logic [23:0] id);
        logic [2:0] k;
        case (id)
            ID_ETT:  k = KIND_TITLE;
            ID_EAR:  k = KIND_ARTIST;
            ID_EAL:  k = KIND_ALBUM;
            ID_LYR:  k = KIND_LYRICS;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: src/lyrics3_field_stream_parser.sv
// Lyrics3 v2 field block parser, one byte per transaction.
//
// Input stream: s_axis_tdata carries the raw byte of the field block,
// s_axis_tlast marks the final byte of the block. Output stream: one
// transaction per kept content byte or field-end marker. m_axis_tdata is the
// byte (zero for a bare marker), m_axis_tuser carries the field kind
// (0 title, 1 artist, 2 album, 3 lyrics) and a byte-valid flag, m_axis_tlast
// marks the end of the emitted field. Bytes of other fields and header bytes
// produce no output transaction.
//
// Path: an accepted byte is held in the input register and parsed from there,
// and its result is loaded into the output register, from which it is
// offered on the master side.
// Throughput: one byte per cycle unless the receiver stalls; all parsing is
// a single pass of small logic between the input and output registers.
// Reset (synchronous, active low) returns the parser to the id phase with
// timestamp stripping off and drops both stage registers. When the receiver
// stalls, the output register holds; the input register still drains bytes
// that produce no result, and a byte with a result waits in the input
// register, which deasserts s_axis_tready once both stages are full.
module lyrics3_field_stream_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // block_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] field_kind, [2] byte_valid
    output logic       m_axis_tlast    // field_end
);
    import lfs_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [2:0] r_out_user;
    logic       r_out_last;

    t_lfs_result res;
    logic        out_free;
    logic        advance;
    logic        s_take;

    // Advance the parsed byte when it has no result or the output slot frees.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!res.has || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    lfs_field_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && res.has) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transaction, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && res.has) begin
            r_out_data <= res.data;
            r_out_user <= {res.byte_valid, res.kind};
            r_out_last <= res.field_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: src/lfs_field_core.sv
module lfs_field_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output lfs_pkg::t_lfs_result o_res
);
    import lfs_pkg::*;

    logic [1:0]        r_phase, n_phase;
    logic [23:0]       r_id, n_id;
    logic [2:0]        r_header_count, n_header_count;
    logic [SIZE_W-1:0] r_size_accum, n_size_accum;
    logic              r_size_stopped, n_size_stopped;
    logic [SIZE_W-1:0] r_content_left, n_content_left;
    logic [1:0]        r_content_index, n_content_index;
    logic              r_stamps_on, n_stamps_on;
    logic [2:0]        r_skip_count, n_skip_count;

    logic [2:0]        kind;
    logic              valid;
    logic              fend;
    logic              open;
    logic              clear_field;
    logic              is_digit;
    logic [SIZE_W-1:0] acc_x10;

    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    // times ten as two shifts, plus the digit value
    assign acc_x10  = {r_size_accum[SIZE_W-4:0], 3'b000}
                    + {r_size_accum[SIZE_W-2:0], 1'b0}
                    + {{(SIZE_W-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_phase         = r_phase;
        n_id            = r_id;
        n_header_count  = r_header_count;
        n_size_accum    = r_size_accum;
        n_size_stopped  = r_size_stopped;
        n_content_left  = r_content_left;
        n_content_index = r_content_index;
        n_stamps_on     = r_stamps_on;
        n_skip_count    = r_skip_count;
        kind            = KIND_NONE;
        valid           = 1'b0;
        fend            = 1'b0;
        open            = 1'b0;
        clear_field     = 1'b0;

        case (r_phase)
            PH_SIZE: begin
                kind = kind_of_id(r_id);
                if (!r_size_stopped && is_digit) begin
                    n_size_accum = acc_x10;
                end else begin
                    n_size_stopped = 1'b1;
                end
                if (r_header_count >= HDR_LAST_CNT) begin
                    if (n_size_accum == '0) begin
                        fend        = !kind[2];
                        clear_field = 1'b1;
                    end else begin
                        n_content_left  = n_size_accum;
                        n_content_index = '0;
                        n_skip_count    = '0;
                        n_header_count  = '0;
                        n_phase         = PH_CONTENT;
                    end
                end else begin
                    n_header_count = r_header_count + 3'd1;
                end
            end
            PH_CONTENT: begin
                kind = kind_of_id(r_id);
                open = 1'b1;
                if (r_id == ID_IND && r_content_index == IND_FLAG_POS && i_byte == CHAR_ONE) begin
                    n_stamps_on = 1'b1;
                end
                if (r_content_index != INDEX_MAX) begin
                    n_content_index = r_content_index + 2'd1;
                end
                if (!kind[2] && kind != KIND_LYRICS) begin
                    valid = 1'b1;
                end else if (kind == KIND_LYRICS && i_byte != CR_BYTE) begin
                    // drop the timestamp opener and its six trailing bytes
                    if (r_skip_count != '0) begin
                        n_skip_count = r_skip_count - 3'd1;
                    end else if (r_stamps_on && i_byte == STAMP_OPEN) begin
                        n_skip_count = STAMP_TAIL;
                    end else begin
                        valid = 1'b1;
                    end
                end
                n_content_left = r_content_left - {{(SIZE_W-1){1'b0}}, 1'b1};
                if (n_content_left == '0) begin
                    fend        = !kind[2];
                    open        = 1'b0;
                    clear_field = 1'b1;
                end
            end
            default: begin
                n_id           = {r_id[15:0], i_byte};
                n_header_count = r_header_count + 3'd1;
                if (r_header_count >= ID_LAST_CNT) begin
                    n_phase = PH_SIZE;
                end
            end
        endcase

        if (clear_field || i_last) begin
            n_phase         = PH_ID;
            n_id            = '0;
            n_header_count  = '0;
            n_size_accum    = '0;
            n_size_stopped  = 1'b0;
            n_content_left  = '0;
            n_content_index = '0;
            n_skip_count    = '0;
        end
        if (i_last) begin
            if (open && !kind[2]) begin
                fend = 1'b1;
            end
            n_stamps_on = 1'b0;
        end

        o_res.has        = valid || fend;
        o_res.data       = valid ? i_byte : 8'h00;
        o_res.kind       = kind[1:0];
        o_res.byte_valid = valid;
        o_res.field_end  = fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_ID;
            r_id            <= '0;
            r_header_count  <= '0;
            r_size_accum    <= '0;
            r_size_stopped  <= 1'b0;
            r_content_left  <= '0;
            r_content_index <= '0;
            r_stamps_on     <= 1'b0;
            r_skip_count    <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_id            <= n_id;
            r_header_count  <= n_header_count;
            r_size_accum    <= n_size_accum;
            r_size_stopped  <= n_size_stopped;
            r_content_left  <= n_content_left;
            r_content_index <= n_content_index;
            r_stamps_on     <= n_stamps_on;
            r_skip_count    <= n_skip_count;
        end
    end

    a_content_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CONTENT |-> r_content_left != '0)
        else $error("content phase with no bytes left");

    a_byte_only_in_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.byte_valid |-> r_phase == PH_CONTENT)
        else $error("content byte emitted outside content phase");

    a_skip_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip_count <= STAMP_TAIL && r_header_count <= HDR_LAST_CNT)
        else $error("skip or header counter out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_phase == PH_ID && !r_stamps_on && r_header_count == '0)
        else $error("block end did not clear parser state");

endmodule

FILE: sim/tb_lyrics3_field_stream_parser.sv
module tb_lyrics3_field_stream_parser;
    import lfs_pkg::*;

    localparam int TOTAL_ITEMS   = 850;
    localparam int HOLD_AT_ITEM  = 300;
    localparam int PAUSE_AT_ITEM = 600;
    localparam int HOLD_CYCLES   = 250;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    // One expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       byte_valid;
        logic       field_end;
    } t_field_out;

    // One input transaction; typed rows carry the result read off by hand
    typedef struct packed {
        logic [7:0] in_byte;
        logic       block_last;
        logic       typed;
        t_field_out out;
    } t_stim_row;

    localparam t_field_out NO_OUT = '0;
    localparam int DIRECTED_ROWS = 29;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // empty title field: marker on the last size digit
        '{"E", 1'b0, 1'b0, NO_OUT},
        '{"T", 1'b0, 1'b0, NO_OUT},
        '{"T", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b1, '{8'h00, KIND_TITLE[1:0], 1'b0, 1'b1}},
        // artist, size stops at the first non-digit, later digits ignored
        '{"E", 1'b0, 1'b0, NO_OUT},
        '{"A", 1'b0, 1'b0, NO_OUT},
        '{"R", 1'b0, 1'b0, NO_OUT},
        '{"1", 1'b0, 1'b0, NO_OUT},
        '{"x", 1'b0, 1'b0, NO_OUT},
        '{"9", 1'b0, 1'b0, NO_OUT},
        '{"9", 1'b0, 1'b0, NO_OUT},
        '{"9", 1'b0, 1'b0, NO_OUT},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_ARTIST[1:0], 1'b1, 1'b1}},
        // lyrics cut short by block end on a dropped CR
        '{"L", 1'b0, 1'b0, NO_OUT},
        '{"Y", 1'b0, 1'b0, NO_OUT},
        '{"R", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b0, 1'b0, NO_OUT},
        '{"9", 1'b0, 1'b0, NO_OUT},
        '{8'h00, 1'b0, 1'b1, '{8'h00, KIND_LYRICS[1:0], 1'b1, 1'b0}},
        '{CR_BYTE, 1'b1, 1'b1, '{8'h00, KIND_LYRICS[1:0], 1'b0, 1'b1}},
        // block end inside an id gives no marker
        '{"I", 1'b0, 1'b0, NO_OUT},
        '{"N", 1'b1, 1'b0, NO_OUT}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;   // block_last
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic [2:0] m_axis_tuser;   // [1:0] field_kind, [2] byte_valid
    logic       m_axis_tlast;   // field_end

    // Sideband that travels with each input transaction
    logic       tx_typed;
    t_field_out tx_out;

    // Parser state mirror
    logic [1:0]        ph       = PH_ID;
    logic [23:0]       id_sh    = '0;
    logic [2:0]        hdr_cnt  = '0;
    logic [SIZE_W-1:0] size_acc = '0;
    logic              size_stop = 1'b0;
    logic [SIZE_W-1:0] left     = '0;
    logic [1:0]        cidx     = '0;
    logic              stamps   = 1'b0;
    logic [2:0]        skip     = '0;

    t_field_out expected_out[$];
    t_stim_row  block_q[$];
    int         n_errors = 0;
    int         n_sent = 0;
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;

    lyrics3_field_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [2:0] field_kind(input logic [23:0] id);
        case (id)
            ID_ETT:  return KIND_TITLE;
            ID_EAR:  return KIND_ARTIST;
            ID_EAL:  return KIND_ALBUM;
            ID_LYR:  return KIND_LYRICS;
            default: return KIND_NONE;
        endcase
    endfunction

    task automatic start_field();
        ph        = PH_ID;
        id_sh     = '0;
        hdr_cnt   = '0;
        size_acc  = '0;
        size_stop = 1'b0;
        left      = '0;
        cidx      = '0;
        skip      = '0;
    endtask

    task automatic clear_parser();
        start_field();
        stamps = 1'b0;
    endtask

    // Advance the parser mirror by one byte; has is set when a transaction results
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic has, output t_field_out res);
        logic [2:0] kind;
        logic       valid;
        logic       fend;
        logic       open;
        kind  = KIND_NONE;
        valid = 1'b0;
        fend  = 1'b0;
        open  = 1'b0;
        case (ph)
            PH_SIZE: begin
                kind = field_kind(id_sh);
                if (!size_stop && b >= CHAR_ZERO && b <= CHAR_NINE)
                    size_acc = SIZE_W'(size_acc * 10 + b - CHAR_ZERO);
                else
                    size_stop = 1'b1;
                if (hdr_cnt >= HDR_LAST_CNT) begin
                    if (size_acc == '0) begin
                        // empty field: marker only for emitted kinds
                        fend = !kind[2];
                        start_field();
                    end else begin
                        left    = size_acc;
                        cidx    = '0;
                        skip    = '0;
                        hdr_cnt = '0;
                        ph      = PH_CONTENT;
                    end
                end else begin
                    hdr_cnt++;
                end
            end
            PH_CONTENT: begin
                kind = field_kind(id_sh);
                open = 1'b1;
                if (id_sh == ID_IND && cidx == IND_FLAG_POS && b == CHAR_ONE)
                    stamps = 1'b1;
                if (cidx < INDEX_MAX)
                    cidx++;
                if (kind < KIND_LYRICS) begin
                    valid = 1'b1;
                end else if (kind == KIND_LYRICS && b != CR_BYTE) begin
                    // drop the stamp opener and the six non-CR bytes after it
                    if (skip != '0)
                        skip--;
                    else if (stamps && b == STAMP_OPEN)
                        skip = STAMP_TAIL;
                    else
                        valid = 1'b1;
                end
                left = left - 1'b1;
                if (left == '0) begin
                    fend = !kind[2];
                    open = 1'b0;
                    start_field();
                end
            end
            default: begin
                id_sh = {id_sh[15:0], b};
                if (hdr_cnt >= ID_LAST_CNT)
                    ph = PH_SIZE;
                hdr_cnt++;
            end
        endcase
        if (last) begin
            if (open && !kind[2])
                fend = 1'b1;
            clear_parser();
        end
        has = valid || fend;
        res.data       = valid ? b : 8'h00;
        res.kind       = kind[1:0];
        res.byte_valid = valid;
        res.field_end  = fend;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Predict on every accepted input transaction, check every output transaction
    always @(posedge i_clk) begin : monitor
        t_field_out pred;
        t_field_out want;
        logic       has;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast, has, pred);
                if (tx_typed && (!has || pred != tx_out)) begin
                    n_errors++;
                    $display("%0t: directed row mismatch, expected %0h, got %0h (has %0b)",
                             $time, tx_out, pred, has);
                end
                if (has)
                    expected_out.push_back(pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected transaction, expected none, got %0h/%0h/%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = expected_out.pop_front();
                    check_field("out_byte", want.data, m_axis_tdata);
                    check_field("field_kind", want.kind, m_axis_tuser[1:0]);
                    check_field("byte_valid", want.byte_valid, m_axis_tuser[2]);
                    check_field("field_end", want.field_end, m_axis_tlast);
                end
            end
        end
    end

    // Receiver: random stalls per transaction, one long hold-off on request
    initial begin : receiver
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                stall = rx_idle ? $urandom_range(0, 7) : 0;
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL lyrics3_field_stream_parser");
        $finish;
    end

    task automatic send_row(input t_stim_row row);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.in_byte;
        s_axis_tlast  <= row.block_last;
        tx_typed      <= row.typed;
        tx_out        <= row.out;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // Hold the input idle until every expected transaction has arrived
    task automatic drain_results(input int settle);
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        t_stim_row r;
        r = '0;
        r.in_byte = b;
        block_q.push_back(r);
    endfunction

    // Build one field block: mostly well-formed fields, some noise and truncation
    task automatic build_block();
        int          sel;
        int          sz;
        int          tmp;
        int          p;
        int          k;
        logic [23:0] id;
        logic [7:0]  dig [5];
        logic        stopped;
        block_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0, 1, 2: id = ID_LYR;
                    3:       id = ID_ETT;
                    4:       id = ID_EAR;
                    5:       id = ID_EAL;
                    6, 7:    id = ID_IND;
                    default: id = 24'($urandom);
                endcase
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    sz = 0;
                else if (sel <= 15)
                    sz = $urandom_range(1, 10);
                else if (sel <= 18)
                    sz = $urandom_range(11, 40);
                else
                    sz = $urandom_range(41, 120);
                tmp = sz;
                for (k = 4; k >= 0; k--) begin
                    dig[k] = CHAR_ZERO + 8'(tmp % 10);
                    tmp = tmp / 10;
                end
                // malformed size: a non-digit stops the number early
                if ($urandom_range(0, 7) == 0) begin
                    p = $urandom_range(0, 4);
                    do dig[p] = 8'($urandom_range(0, 255));
                    while (dig[p] >= CHAR_ZERO && dig[p] <= CHAR_NINE);
                end
                add_byte(id[23:16]);
                add_byte(id[15:8]);
                add_byte(id[7:0]);
                sz = 0;
                stopped = 1'b0;
                for (k = 0; k < 5; k++) begin
                    add_byte(dig[k]);
                    if (!stopped && dig[k] >= CHAR_ZERO && dig[k] <= CHAR_NINE)
                        sz = sz * 10 + int'(dig[k] - CHAR_ZERO);
                    else
                        stopped = 1'b1;
                end
                for (k = 0; k < sz; k++) begin
                    sel = $urandom_range(0, 7);
                    if (id == ID_LYR && sel == 0)
                        add_byte(CR_BYTE);
                    else if (id == ID_LYR && sel <= 2)
                        add_byte(STAMP_OPEN);
                    else if (id == ID_IND && k == 1 && sel != 0)
                        add_byte(CHAR_ONE);
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
            end
            // broken block: end it somewhere inside
            if ($urandom_range(0, 5) == 0 && block_q.size() > 1) begin
                p = $urandom_range(1, block_q.size() - 1);
                while (block_q.size() > p) void'(block_q.pop_back());
            end
        end
        block_q[block_q.size() - 1].block_last = 1'b1;
    endtask

    initial begin : stimulus
        int  k;
        bit  paused;
        paused = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        tx_typed      <= 1'b0;
        tx_out        <= NO_OUT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_row(DIRECTED[k]);

        while (n_sent < TOTAL_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (!hold_req && n_sent >= HOLD_AT_ITEM) begin
                // keep offering bytes back to back while the receiver holds off
                hold_req = 1'b1;
                tx_idle  = 1'b0;
            end
            if (!paused && n_sent >= PAUSE_AT_ITEM) begin
                drain_results(SETTLE_CYCLES);
                paused = 1'b1;
            end
            build_block();
            foreach (block_q[i])
                send_row(block_q[i]);
        end

        drain_results(SETTLE_CYCLES);
        if (n_errors == 0)
            $display("PASS lyrics3_field_stream_parser");
        else
            $display("FAIL lyrics3_field_stream_parser");
        $finish;
    end

endmodule
